@@ rtl/core/lcdn_pkg.sv @@
// ---------------------------------------------------------------------------
// lcdn_pkg
// Shared constants, types and tables for the 4-bit character LCD interface.
// ---------------------------------------------------------------------------
package lcdn_pkg;

  // display geometry
  localparam int WIDTH  = 16;
  localparam int HEIGHT = 2;

  // request codes
  localparam logic [2:0] REQ_INIT  = 3'd0;
  localparam logic [2:0] REQ_WRITE = 3'd1;
  localparam logic [2:0] REQ_SET   = 3'd2;
  localparam logic [2:0] REQ_CLEAR = 3'd3;
  localparam logic [2:0] REQ_HOME  = 3'd4;

  // controller commands
  localparam logic [7:0] ADDR_CMD    = 8'h80;
  localparam logic [7:0] CLEAR_CMD   = 8'h01;
  localparam logic [7:0] FUNC_CMD    = 8'h28;
  localparam logic [7:0] DISP_CMD    = 8'h0C;
  localparam logic [7:0] ENTRY_CMD   = 8'h06;
  localparam logic [3:0] WAKE_NIB    = 4'h3;
  localparam logic [3:0] FOURBIT_NIB = 4'h2;

  localparam logic [5:0] COL_MAX  = 6'd63;
  localparam logic [5:0] LAST_COL = 6'(WIDTH - 1);
  localparam logic [0:0] LAST_ROW = 1'(HEIGHT - 1);
  localparam logic [7:0] CLAMP_COL = 8'(WIDTH - 1);
  localparam logic [7:0] CLAMP_ROW = 8'(HEIGHT - 1);

  // strobe indexes
  localparam logic [3:0] INIT_LAST_IDX = 4'd11;
  localparam logic [3:0] ONE_LAST_IDX  = 4'd1;
  localparam logic [3:0] TWO_LAST_IDX  = 4'd3;

  // job queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one classified request: init sequence, or one or two bytes
  typedef struct packed {
    logic       is_init;
    logic       rs0;
    logic [7:0] byte0;
    logic       has2;
    logic [7:0] byte1;
  } job_t;

  typedef struct packed {
    logic [3:0] nibble;
    logic [3:0] wait_ms;
  } init_strobe_t;

  function automatic logic [7:0] addr_cmd(logic [5:0] c, logic r);
    return ADDR_CMD | {1'b0, r, c};
  endfunction

  function automatic init_strobe_t init_strobe(logic [3:0] idx);
    init_strobe_t s;
    s.wait_ms = 4'd0;
    unique case (idx)
      4'd0: begin
        s.nibble  = WAKE_NIB;
        s.wait_ms = 4'd15;
      end
      4'd1: begin
        s.nibble  = WAKE_NIB;
        s.wait_ms = 4'd5;
      end
      4'd2: begin
        s.nibble  = WAKE_NIB;
        s.wait_ms = 4'd1;
      end
      4'd3:    s.nibble = FOURBIT_NIB;
      4'd4:    s.nibble = FUNC_CMD[7:4];
      4'd5:    s.nibble = FUNC_CMD[3:0];
      4'd6:    s.nibble = DISP_CMD[7:4];
      4'd7:    s.nibble = DISP_CMD[3:0];
      4'd8:    s.nibble = ENTRY_CMD[7:4];
      4'd9:    s.nibble = ENTRY_CMD[3:0];
      4'd10:   s.nibble = CLEAR_CMD[7:4];
      default: s.nibble = CLEAR_CMD[3:0];
    endcase
    return s;
  endfunction

endpackage

@@ rtl/core/lcdn_chan_if.sv @@
// ---------------------------------------------------------------------------
// lcdn channel interfaces
// Valid/ready channels for requests and nibble strobes.
// ---------------------------------------------------------------------------
interface lcdn_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] char_code;
  logic [7:0] col;
  logic [7:0] row;

  modport source (output valid, req_type, char_code, col, row, input ready);
  modport sink (input valid, req_type, char_code, col, row, output ready);
endinterface

interface lcdn_strobe_if;
  logic       valid;
  logic       ready;
  logic       rs;
  logic [3:0] nibble;
  logic [3:0] wait_before_ms;
  logic       last;

  modport source (output valid, rs, nibble, wait_before_ms, last, input ready);
  modport sink (input valid, rs, nibble, wait_before_ms, last, output ready);
endinterface

@@ rtl/core/lcdn_front.sv @@
// ---------------------------------------------------------------------------
// lcdn_front
// Accepts requests, tracks the cursor and turns each request into a job.
// ---------------------------------------------------------------------------
module lcdn_front (
  input  logic               clk,
  input  logic               rst_n,
  lcdn_req_if.sink           req,
  input  logic               q_full,
  output logic               q_push,
  output lcdn_pkg::job_t     q_job
);

  logic [5:0] col_r, col_nxt;
  logic       row_r, row_nxt;
  logic       accept;
  logic       known;
  logic [7:0] cc;
  logic [7:0] rr;

  assign req.ready = !q_full;
  assign accept    = req.valid && req.ready;
  assign q_push    = accept && known;

  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    known       = 1'b1;
    q_job       = '0;
    cc          = (req.col > lcdn_pkg::CLAMP_COL) ? lcdn_pkg::CLAMP_COL : req.col;
    rr          = (req.row > lcdn_pkg::CLAMP_ROW) ? lcdn_pkg::CLAMP_ROW : req.row;
    unique case (req.req_type)
      lcdn_pkg::REQ_INIT: begin
        q_job.is_init = 1'b1;
        col_nxt       = '0;
        row_nxt       = 1'b0;
      end
      lcdn_pkg::REQ_WRITE: begin
        q_job.rs0   = 1'b1;
        q_job.byte0 = req.char_code;
        // wrap to the next row with an explicit address command
        if (col_r >= lcdn_pkg::LAST_COL && row_r < lcdn_pkg::LAST_ROW) begin
          row_nxt     = !row_r;
          col_nxt     = '0;
          q_job.has2  = 1'b1;
          q_job.byte1 = lcdn_pkg::addr_cmd(6'd0, !row_r);
        end else if (col_r < lcdn_pkg::COL_MAX) begin
          col_nxt = col_r + 6'd1;
        end
      end
      lcdn_pkg::REQ_SET: begin
        q_job.byte0 = lcdn_pkg::addr_cmd(cc[5:0], rr[0]);
        col_nxt     = cc[5:0];
        row_nxt     = rr[0];
      end
      lcdn_pkg::REQ_CLEAR: begin
        q_job.byte0 = lcdn_pkg::CLEAR_CMD;
        col_nxt     = '0;
        row_nxt     = 1'b0;
      end
      lcdn_pkg::REQ_HOME: begin
        q_job.byte0 = lcdn_pkg::ADDR_CMD;
        col_nxt     = '0;
        row_nxt     = 1'b0;
      end
      default: known = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= 1'b0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

@@ rtl/core/lcdn_queue.sv @@
// ---------------------------------------------------------------------------
// lcdn_queue
// Short job queue between request decode and the strobe sequencer.
// ---------------------------------------------------------------------------
module lcdn_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lcdn_pkg::job_t     push_job,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output lcdn_pkg::job_t     head_job
);

  lcdn_pkg::job_t                  mem_r [lcdn_pkg::QUEUE_DEPTH];
  logic [lcdn_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [lcdn_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [lcdn_pkg::QCNT_W-1:0]     count_r;

  assign full       = (count_r == lcdn_pkg::QCNT_W'(lcdn_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == lcdn_pkg::QPTR_W'(lcdn_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == lcdn_pkg::QPTR_W'(lcdn_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/lcdn_back.sv @@
// ---------------------------------------------------------------------------
// lcdn_back
// Steps through the strobes of the head job into the output register.
// ---------------------------------------------------------------------------
module lcdn_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  lcdn_pkg::job_t     head_job,
  output logic               pop,
  lcdn_strobe_if.source      strb
);

  logic [3:0]             idx_r;
  logic                   out_valid_r;
  logic                   rs_r;
  logic [3:0]             nibble_r;
  logic [3:0]             wait_r;
  logic                   last_r;
  logic                   load;
  logic                   is_last;
  logic [3:0]             last_idx;
  logic [7:0]             sel_byte;
  logic                   rs_nxt;
  logic [3:0]             nibble_nxt;
  logic [3:0]             wait_nxt;
  lcdn_pkg::init_strobe_t init_s;

  always_comb begin
    init_s   = lcdn_pkg::init_strobe(idx_r);
    sel_byte = idx_r[1] ? head_job.byte1 : head_job.byte0;
    if (head_job.is_init) begin
      last_idx   = lcdn_pkg::INIT_LAST_IDX;
      rs_nxt     = 1'b0;
      nibble_nxt = init_s.nibble;
      wait_nxt   = init_s.wait_ms;
    end else begin
      last_idx   = head_job.has2 ? lcdn_pkg::TWO_LAST_IDX : lcdn_pkg::ONE_LAST_IDX;
      // second byte is always a command
      rs_nxt     = head_job.rs0 && !idx_r[1];
      nibble_nxt = idx_r[0] ? sel_byte[3:0] : sel_byte[7:4];
      wait_nxt   = 4'd0;
    end
    is_last = (idx_r == last_idx);
  end

  assign load = head_valid && (!out_valid_r || strb.ready);
  assign pop  = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r <= is_last ? 4'd0 : idx_r + 4'd1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (strb.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rs_r     <= rs_nxt;
      nibble_r <= nibble_nxt;
      wait_r   <= wait_nxt;
      last_r   <= is_last;
    end
  end

  assign strb.valid          = out_valid_r;
  assign strb.rs             = rs_r;
  assign strb.nibble         = nibble_r;
  assign strb.wait_before_ms = wait_r;
  assign strb.last           = last_r;

endmodule

@@ rtl/core/char_lcd_nibble_interface_top.sv @@
// ---------------------------------------------------------------------------
// char_lcd_nibble_interface_top
// 4-bit character LCD interface with cursor tracking.
// ---------------------------------------------------------------------------
//  channel  | dir | fields                                  | transfer
//  in_ch    | in  | req_type, char_code, col, row           | valid && ready
//  out_ch   | out | rs, nibble, wait_before_ms, last        | valid && ready
//
//  one strobe per cycle from the sequencer while out_ch is ready: a request drains
//  as 2, 4 or 12 strobes (init is 12, a wrapping write is 4, everything else 2)
//  requests are taken one per cycle while the 2-entry job queue has room;
//  unknown request codes are taken and dropped
//  synchronous reset puts the cursor at (0,0) and empties queue and output
//  a stalled out_ch holds the output register; the front keeps decoding
//  until the queue fills
// ---------------------------------------------------------------------------
module char_lcd_nibble_interface_top (
  input  logic          clk,
  input  logic          rst_n,
  lcdn_req_if.sink      in_ch,
  lcdn_strobe_if.source out_ch
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  lcdn_pkg::job_t q_in_job;
  lcdn_pkg::job_t q_head_job;

  lcdn_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (q_in_job)
  );

  lcdn_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_in_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (q_head_job)
  );

  lcdn_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_job   (q_head_job),
    .pop        (q_pop),
    .strb       (out_ch)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full || q_pop)
    else $error("job pushed into a full queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("job popped from an empty queue");

  a_data_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.rs |-> out_ch.wait_before_ms == 4'd0)
    else $error("data strobe carries a delay");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("strobe valid right after reset");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Drives LCD requests through the 4-bit interface and checks every nibble
// strobe against a cycle-free model of the command sequences and cursor.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int          IDLE_PCT       = 25;
  localparam int          REQ_TARGET     = 410;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          SETTLE_CYCLES  = 24;
  localparam int unsigned CALM_START     = 600;
  localparam int unsigned CALM_END       = 1500;

  localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;
  localparam logic [7:0] ROW_STRIDE       = 8'h40;
  localparam logic [3:0] WAIT_POWER_UP    = 4'd15;
  localparam logic [3:0] WAIT_WAKE_2      = 4'd5;
  localparam logic [3:0] WAIT_WAKE_3      = 4'd1;
  localparam logic [3:0] WAIT_NONE        = 4'd0;

  typedef struct packed {
    logic       rs;
    logic [3:0] nibble;
    logic [3:0] wait_ms;
    logic       last;
  } strobe_t;

  typedef struct {
    logic [2:0] req_type;
    logic [7:0] char_code;
    logic [7:0] col;
    logic [7:0] row;
    bit         drain_first;
  } lcd_req_t;

  logic clk = 1'b0;
  logic rst_n;

  lcdn_req_if    in_ch ();
  lcdn_strobe_if out_ch ();

  char_lcd_nibble_interface_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  lcd_req_t    req_q[$];
  strobe_t     strobe_q[$];
  strobe_t     burst[$];
  logic [5:0]  col_now = '0;
  logic        row_now = 1'b0;
  int          errors = 0;
  int          real_reqs = 0;
  int unsigned cyc = 0;
  int          quiet = 0;
  logic        drained = 1'b0;
  logic        calm;

  assign calm = (cyc >= CALM_START) && (cyc < CALM_END);

  // ---------------------------------------------------------------- model

  task automatic add_nibble(logic rs, logic [3:0] nib, logic [3:0] wait_ms);
    strobe_t s;
    s = '{rs: rs, nibble: nib, wait_ms: wait_ms, last: 1'b0};
    burst.push_back(s);
  endtask

  task automatic add_byte(logic rs, logic [7:0] b);
    add_nibble(rs, b[7:4], WAIT_NONE);
    add_nibble(rs, b[3:0], WAIT_NONE);
  endtask

  function automatic logic [7:0] cursor_addr(logic [7:0] c, logic [7:0] r);
    return lcdn_pkg::ADDR_CMD | 8'(r * ROW_STRIDE + c);
  endfunction

  task automatic predict_strobes(lcd_req_t q);
    logic [7:0] c;
    logic [7:0] r;
    burst.delete();
    case (q.req_type)
      lcdn_pkg::REQ_INIT: begin
        add_nibble(1'b0, lcdn_pkg::WAKE_NIB, WAIT_POWER_UP);
        add_nibble(1'b0, lcdn_pkg::WAKE_NIB, WAIT_WAKE_2);
        add_nibble(1'b0, lcdn_pkg::WAKE_NIB, WAIT_WAKE_3);
        add_nibble(1'b0, lcdn_pkg::FOURBIT_NIB, WAIT_NONE);
        add_byte(1'b0, lcdn_pkg::FUNC_CMD);
        add_byte(1'b0, lcdn_pkg::DISP_CMD);
        add_byte(1'b0, lcdn_pkg::ENTRY_CMD);
        add_byte(1'b0, lcdn_pkg::CLEAR_CMD);
        col_now = '0;
        row_now = 1'b0;
      end
      lcdn_pkg::REQ_WRITE: begin
        add_byte(1'b1, q.char_code);
        if (col_now >= lcdn_pkg::LAST_COL && row_now < lcdn_pkg::LAST_ROW) begin
          row_now = row_now + 1'b1;
          col_now = '0;
          add_byte(1'b0, cursor_addr({2'b0, col_now}, {7'b0, row_now}));
        end else if (col_now < lcdn_pkg::COL_MAX) begin
          col_now = col_now + 1'b1;
        end
      end
      lcdn_pkg::REQ_SET: begin
        c = (q.col > lcdn_pkg::CLAMP_COL) ? lcdn_pkg::CLAMP_COL : q.col;
        r = (q.row > lcdn_pkg::CLAMP_ROW) ? lcdn_pkg::CLAMP_ROW : q.row;
        add_byte(1'b0, cursor_addr(c, r));
        col_now = c[5:0];
        row_now = r[0];
      end
      lcdn_pkg::REQ_CLEAR: begin
        add_byte(1'b0, lcdn_pkg::CLEAR_CMD);
        col_now = '0;
        row_now = 1'b0;
      end
      lcdn_pkg::REQ_HOME: begin
        add_byte(1'b0, lcdn_pkg::ADDR_CMD);
        col_now = '0;
        row_now = 1'b0;
      end
      default: ;
    endcase
    if (burst.size() != 0) burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i]) strobe_q.push_back(burst[i]);
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // ------------------------------------------------------------- stimulus

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_request(logic [2:0] t, logic [7:0] ch, logic [7:0] c,
                               logic [7:0] r, bit hold);
    lcd_req_t q;
    q = '{req_type: t, char_code: ch, col: c, row: r, drain_first: hold};
    req_q.push_back(q);
    if (t <= lcdn_pkg::REQ_HOME) real_reqs++;
  endtask

  initial begin
    int         pick;
    int         kind;
    int         sat_runs;
    logic [2:0] t;

    rst_n    = 1'b0;
    sat_runs = 0;

    // directed: extremes, every request, clamping, wrap, last-row overrun
    queue_request(lcdn_pkg::REQ_INIT, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_request(lcdn_pkg::REQ_WRITE, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_request(lcdn_pkg::REQ_WRITE, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    queue_request(lcdn_pkg::REQ_SET, 8'h00, 8'hFF, 8'hFF, 1'b0);
    queue_request(lcdn_pkg::REQ_WRITE, 8'h5A, 8'h00, 8'h00, 1'b0);
    queue_request(lcdn_pkg::REQ_SET, 8'h00, 8'd15, 8'h00, 1'b0);
    queue_request(lcdn_pkg::REQ_WRITE, 8'hA5, 8'h00, 8'h00, 1'b0);
    queue_request(lcdn_pkg::REQ_SET, 8'h00, 8'h00, 8'h00, 1'b0);
    queue_request(lcdn_pkg::REQ_SET, 8'h00, 8'hAA, 8'h55, 1'b0);
    queue_request(lcdn_pkg::REQ_SET, 8'h00, 8'h55, 8'hAA, 1'b0);
    queue_request(lcdn_pkg::REQ_SET, 8'h00, 8'd14, 8'h00, 1'b0);
    queue_request(lcdn_pkg::REQ_WRITE, rnd_byte(), 8'h00, 8'h00, 1'b0);
    queue_request(lcdn_pkg::REQ_WRITE, rnd_byte(), 8'h00, 8'h00, 1'b0);
    queue_request(lcdn_pkg::REQ_WRITE, rnd_byte(), 8'h00, 8'h00, 1'b0);
    queue_request(lcdn_pkg::REQ_CLEAR, rnd_byte(), rnd_byte(), rnd_byte(), 1'b0);
    queue_request(lcdn_pkg::REQ_WRITE, rnd_byte(), 8'h00, 8'h00, 1'b0);
    queue_request(lcdn_pkg::REQ_HOME, rnd_byte(), rnd_byte(), rnd_byte(), 1'b0);
    queue_request(REQ_UNUSED_FIRST, rnd_byte(), rnd_byte(), rnd_byte(), 1'b0);
    queue_request(3'(REQ_UNUSED_FIRST + 1'b1), rnd_byte(), rnd_byte(), rnd_byte(), 1'b0);
    queue_request(REQ_UNUSED_LAST, rnd_byte(), rnd_byte(), rnd_byte(), 1'b0);
    queue_request(lcdn_pkg::REQ_SET, 8'h00, 8'd3, 8'd1, 1'b0);
    // sender holds off until the display side has drained
    queue_request(lcdn_pkg::REQ_INIT, rnd_byte(), rnd_byte(), rnd_byte(), 1'b1);

    while (real_reqs < REQ_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        // park near the end of the top row and type across the wrap
        queue_request(lcdn_pkg::REQ_SET, rnd_byte(), 8'($urandom_range(10, 255)), 8'h00,
                      1'b0);
        repeat ($urandom_range(1, 8)) queue_request(lcdn_pkg::REQ_WRITE, rnd_byte(),
                                                     rnd_byte(), rnd_byte(), 1'b0);
      end else if (pick < 40 && sat_runs < 2) begin
        // bottom row: type until the column counter pins at its top
        sat_runs++;
        queue_request(lcdn_pkg::REQ_SET, rnd_byte(), rnd_byte(),
                      8'($urandom_range(1, 255)), 1'b0);
        repeat ($urandom_range(66, 72)) queue_request(lcdn_pkg::REQ_WRITE, rnd_byte(),
                                                       rnd_byte(), rnd_byte(), 1'b0);
      end else begin
        kind = $urandom_range(0, 99);
        if (kind < 5) t = lcdn_pkg::REQ_INIT;
        else if (kind < 10) t = 3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
        else t = 3'($urandom_range(lcdn_pkg::REQ_WRITE, lcdn_pkg::REQ_HOME));
        queue_request(t, rnd_byte(), rnd_byte(), rnd_byte(), $urandom_range(0, 99) < 2);
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (req_q.size() != 0 || in_ch.valid || strobe_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // ------------------------------------------------------------ driver

  always @(negedge clk) drained <= (strobe_q.size() == 0) && !in_ch.valid;

  always @(posedge clk) begin
    lcd_req_t nxt;
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.req_type  <= lcdn_pkg::REQ_INIT;
      in_ch.char_code <= '0;
      in_ch.col       <= '0;
      in_ch.row       <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (req_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT) &&
          (!req_q[0].drain_first || drained)) begin
        nxt = req_q.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.req_type  <= nxt.req_type;
        in_ch.char_code <= nxt.char_code;
        in_ch.col       <= nxt.col;
        in_ch.row       <= nxt.row;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // ------------------------------------------------------------ monitor

  always @(posedge clk) begin
    lcd_req_t seen;
    strobe_t  want;
    cyc <= cyc + 1;
    if (rst_n) begin
      // predict first so a same-edge strobe finds its expectation
      if (in_ch.valid && in_ch.ready) begin
        seen = '{req_type: in_ch.req_type, char_code: in_ch.char_code,
                 col: in_ch.col, row: in_ch.row, drain_first: 1'b0};
        predict_strobes(seen);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (strobe_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected strobe, expected none, actual rs %0d nibble %0h %s",
                   $time, out_ch.rs, out_ch.nibble,
                   $sformatf("wait %0d last %0d", out_ch.wait_before_ms, out_ch.last));
        end else begin
          want = strobe_q.pop_front();
          check_field("rs", want.rs, out_ch.rs);
          check_field("nibble", want.nibble, out_ch.nibble);
          check_field("wait_before_ms", want.wait_ms, out_ch.wait_before_ms);
          check_field("last", want.last, out_ch.last);
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet <= 0;
      end else if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

endmodule

@@ sim.f @@
rtl/core/lcdn_pkg.sv
rtl/core/lcdn_chan_if.sv
rtl/core/lcdn_front.sv
rtl/core/lcdn_queue.sv
rtl/core/lcdn_back.sv
rtl/core/char_lcd_nibble_interface_top.sv
tb/tb_top.sv
